// ----- rtl/pbrs_pkg.sv -----
package pbrs_pkg;

  // field widths of the transaction payloads
  localparam int MASK_W    = 4;
  localparam int RUNTIME_W = 32;
  localparam int BUDGET_W  = 16;
  localparam int LEVEL_W   = 2;

  // reload register file
  localparam int NUM_REGS  = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_RELOAD_LOW      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RELOAD_NORMAL   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RELOAD_HIGH     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_RELOAD_CRITICAL = 2'd3;

  typedef logic [NUM_REGS-1:0][BUDGET_W-1:0] reload_set_t;

  // reset values, indexed by register
  localparam reload_set_t RELOAD_RESET = {16'd600, 16'd200, 16'd150, 16'd50};

  // command codes
  localparam logic CMD_PICK   = 1'b0;
  localparam logic CMD_CHARGE = 1'b1;

  // smallest amount a charge takes off a budget
  localparam logic [RUNTIME_W-1:0] MIN_CHARGE = 32'd1;

  // one result transaction
  typedef struct packed {
    logic                granted;
    logic [LEVEL_W-1:0]  grant_level;
    logic [BUDGET_W-1:0] budget_left;
    logic                pass_ended;
    logic                reloaded;
  } result_t;

  // levels above the register file reload from the critical register
  function automatic logic [BUDGET_W-1:0] reload_value(reload_set_t regs, int lvl);
    logic [BUDGET_W-1:0] val;
    val = regs[REG_RELOAD_CRITICAL];
    if (lvl < NUM_REGS) begin
      val = regs[lvl[REG_IDX_W-1:0]];
    end
    return val;
  endfunction

endpackage

// ----- rtl/pbrs_step.sv -----
module pbrs_step #(
  parameter int LEVELS = 4,
  parameter int CW     = $clog2(LEVELS)
) (
  input  logic                                          cmd,
  input  logic [pbrs_pkg::MASK_W-1:0]                   nonempty_mask,
  input  logic [pbrs_pkg::RUNTIME_W-1:0]                runtime_us,
  input  logic [LEVELS-1:0][pbrs_pkg::BUDGET_W-1:0]     level_budget,
  input  logic [CW-1:0]                                 pass_cursor,
  input  pbrs_pkg::reload_set_t                         reload_set,
  output logic [LEVELS-1:0][pbrs_pkg::BUDGET_W-1:0]     budget_next,
  output logic [CW-1:0]                                 cursor_next,
  output pbrs_pkg::result_t                             res
);

  localparam int MW = (LEVELS > pbrs_pkg::MASK_W) ? LEVELS : pbrs_pkg::MASK_W;

  logic [MW-1:0]                     mask_wide;
  logic [LEVELS-1:0]                 mask_ext;
  logic [pbrs_pkg::RUNTIME_W-1:0]    charge;
  logic [pbrs_pkg::BUDGET_W-1:0]     cur_budget;
  logic [pbrs_pkg::BUDGET_W-1:0]     charged;
  logic                              found;
  logic                              any_budget;
  logic [CW-1:0]                     pick;

  // mask bits above the input field read as empty
  assign mask_wide = MW'(nonempty_mask);
  assign mask_ext  = mask_wide[LEVELS-1:0];

  // saturating charge against the level under the cursor
  assign charge     = (runtime_us == '0) ? pbrs_pkg::MIN_CHARGE : runtime_us;
  assign cur_budget = level_budget[pass_cursor];
  assign charged    = (charge >= pbrs_pkg::RUNTIME_W'(cur_budget)) ? '0
                    : cur_budget - charge[pbrs_pkg::BUDGET_W-1:0];

  // priority search from the cursor downward, highest eligible wins
  always_comb begin
    found      = 1'b0;
    any_budget = 1'b0;
    pick       = '0;
    for (int p = 0; p < LEVELS; p++) begin
      if (mask_ext[p] && (level_budget[p] != '0)) begin
        any_budget = 1'b1;
        if (p <= int'(pass_cursor)) begin
          found = 1'b1;
          pick  = CW'(p);
        end
      end
    end
  end

  // next state and result
  always_comb begin
    budget_next = level_budget;
    cursor_next = pass_cursor;
    res         = '0;
    if (cmd == pbrs_pkg::CMD_CHARGE) begin
      budget_next[pass_cursor] = charged;
      res.grant_level          = pbrs_pkg::LEVEL_W'(pass_cursor);
      res.budget_left          = charged;
    end else if (found) begin
      cursor_next     = pick;
      res.granted     = 1'b1;
      res.grant_level = pbrs_pkg::LEVEL_W'(pick);
      res.budget_left = level_budget[pick];
    end else begin
      cursor_next    = CW'(LEVELS - 1);
      res.pass_ended = 1'b1;
      res.reloaded   = !any_budget;
      if (!any_budget) begin
        for (int i = 0; i < LEVELS; i++) begin
          budget_next[i] = pbrs_pkg::reload_value(reload_set, i);
        end
      end
    end
  end

endmodule

// ----- rtl/priority_budget_round_scheduler_unit.sv -----
// an accepted item is held in the input register, its result in the result register
// throughput: one transaction per cycle, limited only by the output stall
// the budget and cursor update sits between the input and result registers
// reset: budgets take the reload reset values, cursor returns to critical,
// both pipeline stages empty
module priority_budget_round_scheduler_unit #(
  parameter int LEVELS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              cmd,
  input  logic [pbrs_pkg::MASK_W-1:0]       nonempty_mask,
  input  logic [pbrs_pkg::RUNTIME_W-1:0]    runtime_us,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              granted,
  output logic [pbrs_pkg::LEVEL_W-1:0]      grant_level,
  output logic [pbrs_pkg::BUDGET_W-1:0]     budget_left,
  output logic                              pass_ended,
  output logic                              reloaded,
  input  logic                              cfg_write,
  input  logic [pbrs_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [pbrs_pkg::BUDGET_W-1:0]     cfg_data
);

  localparam int CW = $clog2(LEVELS);

  pbrs_pkg::reload_set_t                        reload_set;
  logic [LEVELS-1:0][pbrs_pkg::BUDGET_W-1:0]    level_budget;
  logic [LEVELS-1:0][pbrs_pkg::BUDGET_W-1:0]    budget_next;
  logic [CW-1:0]                                pass_cursor;
  logic [CW-1:0]                                cursor_next;

  logic                                         s1_valid;
  logic                                         s1_cmd;
  logic [pbrs_pkg::MASK_W-1:0]                  s1_mask;
  logic [pbrs_pkg::RUNTIME_W-1:0]               s1_runtime;
  pbrs_pkg::result_t                            step_res;
  pbrs_pkg::result_t                            out_res;
  logic                                         accept;
  logic                                         advance;

  // pipeline handshake
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // reload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reload_set <= pbrs_pkg::RELOAD_RESET;
    end else if (cfg_write) begin
      reload_set[cfg_index] <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd     <= cmd;
      s1_mask    <= nonempty_mask;
      s1_runtime <= runtime_us;
    end
  end

  // scheduling step
  pbrs_step #(
    .LEVELS (LEVELS),
    .CW     (CW)
  ) u_step (
    .cmd           (s1_cmd),
    .nonempty_mask (s1_mask),
    .runtime_us    (s1_runtime),
    .level_budget  (level_budget),
    .pass_cursor   (pass_cursor),
    .reload_set    (reload_set),
    .budget_next   (budget_next),
    .cursor_next   (cursor_next),
    .res           (step_res)
  );

  // budgets and cursor update as the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        level_budget[i] <= pbrs_pkg::reload_value(pbrs_pkg::RELOAD_RESET, i);
      end
      pass_cursor <= CW'(LEVELS - 1);
    end else if (advance) begin
      level_budget <= budget_next;
      pass_cursor  <= cursor_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign granted     = out_res.granted;
  assign grant_level = out_res.grant_level;
  assign budget_left = out_res.budget_left;
  assign pass_ended  = out_res.pass_ended;
  assign reloaded    = out_res.reloaded;

  // a result is a grant, a pass end or a charge, never two of them
  a_grant_or_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(granted && pass_ended))
    else $error("grant and pass end in one result");

  // a reload only happens at a pass end
  a_reload_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reloaded) |-> pass_ended)
    else $error("reload without pass end");

  // a grant is only given to a level with budget
  a_grant_budget: assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted) |-> (budget_left != '0))
    else $error("grant to a level with no budget");

  // a pass end puts the cursor back on critical
  a_cursor_home: assert property (@(posedge clk) disable iff (rst)
    (advance && step_res.pass_ended) |=> (pass_cursor == CW'(LEVELS - 1)))
    else $error("cursor not back on critical after pass end");

endmodule
